// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; they compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define RRB_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define RRB_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RRB_ASSERT(name, clk, rst_n, prop, msg)
`define RRB_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/rrb_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer package
// Widths, defaults, action codes and insert status codes shared by the
// reorder buffer and its channel interfaces.
// ----------------------------------------------------------------------------
package rrb_pkg;

	// Default geometry.
	localparam int unsigned WINDOW_DEF    = 64;
	localparam int unsigned PAYLOAD_W_DEF = 16;

	// Fixed field widths on the channels.
	localparam int unsigned SEQ_W      = 32;
	localparam int unsigned PAY_PORT_W = 16;
	localparam int unsigned ACT_W      = 2;
	localparam int unsigned STAT_W     = 2;

	typedef logic [SEQ_W-1:0]      seq_t;
	typedef logic [PAY_PORT_W-1:0] pay_t;
	typedef logic [ACT_W-1:0]      action_t;
	typedef logic [STAT_W-1:0]     status_t;

	// Action codes.
	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_TAKE   = 2'd1;
	localparam action_t ACT_CLEAR  = 2'd2;
	localparam action_t ACT_NOP    = 2'd3;

	// Insert status codes.
	localparam status_t STAT_STORED   = 2'd0;
	localparam status_t STAT_REPLACED = 2'd1;
	localparam status_t STAT_DROPPED  = 2'd2;

endpackage

// File: rtl/core/rrb_cmd_if.sv
// ----------------------------------------------------------------------------
// Reorder buffer command channel
// Valid/ready channel that carries one command word into the reorder buffer.
// ----------------------------------------------------------------------------
interface rrb_cmd_if import rrb_pkg::*;;
	logic    valid;
	logic    ready;
	action_t action;
	seq_t    seq_id;
	pay_t    payload_in;

	modport source (output valid, action, seq_id, payload_in, input ready);
	modport sink (input valid, action, seq_id, payload_in, output ready);
endinterface

// File: rtl/core/rrb_rsp_if.sv
// ----------------------------------------------------------------------------
// Reorder buffer response channel
// Valid/ready channel that carries one result word out of the reorder buffer.
// ----------------------------------------------------------------------------
interface rrb_rsp_if import rrb_pkg::*;;
	logic    valid;
	logic    ready;
	logic    delivered;
	seq_t    delivered_id;
	pay_t    delivered_payload;
	status_t insert_status;
	logic    head_ready;
	seq_t    next_expected;

	modport source (output valid, delivered, delivered_id, delivered_payload,
		insert_status, head_ready, next_expected, input ready);
	modport sink (input valid, delivered, delivered_id, delivered_payload,
		insert_status, head_ready, next_expected, output ready);
endinterface

// File: rtl/core/rrb_slot_store.sv
// ----------------------------------------------------------------------------
// Reorder buffer slot store
// Synchronous slot memory with one write port and two registered read
// ports. Each entry holds a filled flag above the payload handle; the second
// port returns only the filled flag.
// ----------------------------------------------------------------------------
module rrb_slot_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 17
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data_a,
	output logic          rd_filled_b
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_a_q;
	logic          rd_filled_b_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read ports, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_q   <= mem_q[rd_addr_a];
			rd_filled_b_q <= mem_q[rd_addr_b][DW-1];
		end
	end

	assign rd_data_a   = rd_data_a_q;
	assign rd_filled_b = rd_filled_b_q;

endmodule

// File: rtl/core/reliable_reorder_buffer.sv
// ----------------------------------------------------------------------------
// Reliable reorder buffer
// Receive-side reorder buffer: each command word inserts a payload handle
// under its sequence number, takes the next in-order handle, or clears the
// buffer. Slots live in a synchronous memory indexed by sequence number
// modulo WINDOW. A command is accepted, its slot is read at that edge, and on
// the following cycle the slot is written back and the result word is loaded
// into the output register. Commands are handled one at a time: the next one
// is accepted only after this write-back, and only while the output register
// has room; this is set by the read-then-write of the slot memory. A clear
// command additionally sweeps every slot of the memory, and after reset the
// same clearing pass runs before the first command is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reliable_reorder_buffer import rrb_pkg::*; #(
	parameter int unsigned WINDOW    = WINDOW_DEF,
	parameter int unsigned PAYLOAD_W = PAYLOAD_W_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rrb_cmd_if.sink   cmd,
	rrb_rsp_if.source rsp
);

	localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SW = (PAYLOAD_W < PAY_PORT_W) ? PAYLOAD_W : PAY_PORT_W;
	localparam int unsigned DW = SW + 1;

	localparam logic [AW-1:0]    LAST_SLOT  = AW'(WINDOW - 1);
	localparam logic [AW:0]      WINDOW_X   = (AW+1)'(WINDOW);
	localparam logic [SEQ_W-1:0] WINDOW_SEQ = SEQ_W'(WINDOW);

	// Sequencer states.
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] sweep_q;
	seq_t          expected_q;
	logic [AW-1:0] exp_slot_q;
	logic          head_q;

	action_t       action_s1;
	logic [SW-1:0] pay_s1;
	logic          in_win_s1;
	logic [AW-1:0] slot_s1;

	logic          rsp_valid_q;
	logic          delivered_q;
	seq_t          delivered_id_q;
	pay_t          delivered_payload_q;
	status_t       insert_status_q;
	logic          head_ready_q;
	seq_t          next_expected_q;

	logic          accept;
	seq_t          offset;
	logic          in_win;
	logic [AW:0]   slot_sum;
	logic [AW:0]   slot_wrap;
	logic [AW-1:0] ins_slot;
	logic [AW-1:0] succ_slot;
	logic [AW-1:0] rd_addr_a;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic [DW-1:0] rd_data_a;
	logic          rd_filled_b;

	logic          ex_wr_en;
	logic [AW-1:0] ex_wr_addr;
	logic [DW-1:0] ex_wr_data;
	logic          ex_delivered;
	seq_t          ex_delivered_id;
	pay_t          ex_delivered_payload;
	status_t       ex_status;
	seq_t          exp_n;
	logic [AW-1:0] exp_slot_n;
	logic          head_n;

	// Handshake: one command at a time, and only with room in the output.
	assign cmd.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = cmd.valid && cmd.ready;

	// Window check and slot of the inserted sequence number. Below the 2^32
	// wrap the slot is the head slot plus the offset, folded once; across the
	// wrap the sequence number is already below WINDOW and is its own slot.
	assign offset    = cmd.seq_id - expected_q;
	assign in_win    = offset < WINDOW_SEQ;
	assign slot_sum  = {1'b0, exp_slot_q} + {1'b0, offset[AW-1:0]};
	assign slot_wrap = (slot_sum >= WINDOW_X) ? (slot_sum - WINDOW_X) : slot_sum;
	assign ins_slot  = (cmd.seq_id < expected_q) ? cmd.seq_id[AW-1:0] : slot_wrap[AW-1:0];

	// Slot of the sequence number after the expected one.
	always_comb begin
		if (expected_q == '1 || exp_slot_q == LAST_SLOT) begin
			succ_slot = '0;
		end else begin
			succ_slot = exp_slot_q + AW'(1);
		end
	end

	assign rd_addr_a = (cmd.action == ACT_INSERT) ? ins_slot : exp_slot_q;

	// Execute stage: work out the write-back and the result word.
	always_comb begin
		ex_wr_en             = 1'b0;
		ex_wr_addr           = slot_s1;
		ex_wr_data           = {1'b1, pay_s1};
		ex_delivered         = 1'b0;
		ex_delivered_id      = '0;
		ex_delivered_payload = '0;
		ex_status            = STAT_STORED;
		exp_n                = expected_q;
		exp_slot_n           = exp_slot_q;
		head_n               = head_q;
		case (action_s1)
			ACT_INSERT: begin
				if (in_win_s1) begin
					ex_wr_en  = 1'b1;
					ex_status = rd_data_a[DW-1] ? STAT_REPLACED : STAT_STORED;
					head_n    = head_q || (slot_s1 == exp_slot_q);
				end else begin
					ex_status = STAT_DROPPED;
				end
			end
			ACT_TAKE: begin
				if (head_q) begin
					ex_wr_en             = 1'b1;
					ex_wr_addr           = exp_slot_q;
					ex_wr_data           = '0;
					ex_delivered         = 1'b1;
					ex_delivered_id      = expected_q;
					ex_delivered_payload = PAY_PORT_W'(rd_data_a[SW-1:0]);
					exp_n                = expected_q + SEQ_W'(1);
					exp_slot_n           = succ_slot;
					// At the 2^32 wrap the next slot can be the one just freed.
					head_n               = rd_filled_b && (succ_slot != exp_slot_q);
				end
			end
			ACT_CLEAR: begin
				exp_n      = '0;
				exp_slot_n = '0;
				head_n     = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// The clearing sweep owns the write port while it runs.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
			wr_data = '0;
		end else begin
			wr_en   = (state_q == ST_EXEC) && ex_wr_en;
			wr_addr = ex_wr_addr;
			wr_data = ex_wr_data;
		end
	end

	rrb_slot_store #(
		.DEPTH (WINDOW),
		.AW    (AW),
		.DW    (DW)
	) u_slot_store (
		.clk         (clk),
		.rd_en       (accept),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (succ_slot),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_data_a   (rd_data_a),
		.rd_filled_b (rd_filled_b)
	);

	// Sequencer, expected number and head flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			sweep_q    <= '0;
			expected_q <= '0;
			exp_slot_q <= '0;
			head_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sweep_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					expected_q <= exp_n;
					exp_slot_q <= exp_slot_n;
					head_q     <= head_n;
					if (action_s1 == ACT_CLEAR) begin
						state_q <= ST_CLEAR;
						sweep_q <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					sweep_q <= '0;
				end
			endcase
		end
	end

	// Command held for the execute stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= cmd.action;
			pay_s1    <= cmd.payload_in[SW-1:0];
			in_win_s1 <= in_win;
			slot_s1   <= ins_slot;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_EXEC) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register word.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			delivered_q         <= ex_delivered;
			delivered_id_q      <= ex_delivered_id;
			delivered_payload_q <= ex_delivered_payload;
			insert_status_q     <= ex_status;
			head_ready_q        <= head_n;
			next_expected_q     <= exp_n;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.delivered         = delivered_q;
	assign rsp.delivered_id      = delivered_id_q;
	assign rsp.delivered_payload = delivered_payload_q;
	assign rsp.insert_status     = insert_status_q;
	assign rsp.head_ready        = head_ready_q;
	assign rsp.next_expected     = next_expected_q;

	// An accepted command always moves to the execute stage.
	`RRB_ASSERT(a_accept_exec, clk, arst_n, (cmd.valid && cmd.ready) |=> (state_q == ST_EXEC), "accepted command did not reach execute")
	// A delivered word always advances the expected number by one.
	`RRB_ASSERT(a_deliver_adv, clk, arst_n, (rsp.valid && rsp.delivered) |-> (rsp.next_expected == rsp.delivered_id + 32'd1), "delivery without advance")
	// The execute stage never finds the output register occupied.
	`RRB_ASSERT_NEVER(a_exec_room, clk, arst_n, (state_q == ST_EXEC) && rsp_valid_q, "output register full in execute")

endmodule
